[rtl/fdss_pkg.sv]
// shared types, constants and helper functions of the seven-segment scanner
`timescale 1ns / 1ps
package fdss_pkg;

  // field widths
  localparam int unsigned ValueW = 14;
  localparam int unsigned DigitW = 4;
  localparam int unsigned NumDigits = 4;
  localparam int unsigned PosW = 2;
  localparam int unsigned SegW = 8;
  localparam int unsigned HundredsW = 7;

  // command codes on the input channel
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTick = 1'b1;

  // value range and digit split constants
  localparam logic [ValueW-1:0] MaxShown = 14'd9999;
  localparam logic [12:0] RecipHundred = 13'd5243;  // 2^19 / 100, rounded up
  localparam int unsigned RecipHundredShift = 19;
  localparam logic [7:0] RecipTen = 8'd205;          // 2^11 / 10, rounded up
  localparam logic [6:0] Hundred = 7'd100;
  localparam logic [6:0] Ten = 7'd10;

  // display weights of the upper three positions
  localparam logic [ValueW-1:0] WeightTens = 14'd10;
  localparam logic [ValueW-1:0] WeightHundreds = 14'd100;
  localparam logic [ValueW-1:0] WeightThousands = 14'd1000;

  // scan positions
  localparam logic [PosW-1:0] PosOnes = 2'd0;
  localparam logic [PosW-1:0] PosTens = 2'd1;
  localparam logic [PosW-1:0] PosHundreds = 2'd2;
  localparam logic [PosW-1:0] PosThousands = 2'd3;

  // active-low segment patterns, decimal point in bit 7
  localparam logic [SegW-1:0] SegZero = 8'b11000000;
  localparam logic [SegW-1:0] SegOne = 8'b11111001;
  localparam logic [SegW-1:0] SegTwo = 8'b10100100;
  localparam logic [SegW-1:0] SegThree = 8'b10110000;
  localparam logic [SegW-1:0] SegFour = 8'b10011001;
  localparam logic [SegW-1:0] SegFive = 8'b10010010;
  localparam logic [SegW-1:0] SegSix = 8'b10000010;
  localparam logic [SegW-1:0] SegSeven = 8'b11111000;
  localparam logic [SegW-1:0] SegEight = 8'b10000000;
  localparam logic [SegW-1:0] SegNine = 8'b10010000;
  localparam logic [SegW-1:0] SegBlank = 8'b11111111;
  localparam logic [SegW-1:0] DpLitMask = 8'b01111111;

  // kind of a queued request
  typedef enum logic {
    KindLoad = 1'b0,
    KindTick = 1'b1
  } kind_e;

  // one queue entry: a classified request with its digits already split
  typedef struct packed {
    kind_e kind;
    logic [NumDigits-1:0][DigitW-1:0] digits;
    logic [ValueW-1:0] value;
  } entry_t;

  // split 0..99 into tens and ones, returned as {tens, ones}
  function automatic logic [2*DigitW-1:0] split99(input logic [6:0] x);
    logic [14:0] prod;
    logic [DigitW-1:0] tens;
    logic [6:0] rest;
    prod = 15'(x) * 15'(RecipTen);
    tens = prod[14:11];
    rest = x - 7'(tens) * Ten;
    return {tens, rest[DigitW-1:0]};
  endfunction

  // seven-segment pattern of one bcd digit
  function automatic logic [SegW-1:0] seg_lut(input logic [DigitW-1:0] d);
    logic [SegW-1:0] seg;
    unique case (d)
      4'd0:    seg = SegZero;
      4'd1:    seg = SegOne;
      4'd2:    seg = SegTwo;
      4'd3:    seg = SegThree;
      4'd4:    seg = SegFour;
      4'd5:    seg = SegFive;
      4'd6:    seg = SegSix;
      4'd7:    seg = SegSeven;
      4'd8:    seg = SegEight;
      4'd9:    seg = SegNine;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

  // true when the shown value reaches the weight of the position; ones is always lit
  function automatic logic pos_lit(input logic [PosW-1:0] pos,
                                   input logic [ValueW-1:0] shown);
    logic lit;
    unique case (pos)
      PosOnes:      lit = 1'b1;
      PosTens:      lit = (shown >= WeightTens);
      PosHundreds:  lit = (shown >= WeightHundreds);
      PosThousands: lit = (shown >= WeightThousands);
      default:      lit = 1'b1;
    endcase
    return lit;
  endfunction

endpackage

[rtl/fdss_front.sv]
// front end: accepts requests, clamps values and splits them into bcd digits
`timescale 1ns / 1ps
module fdss_front #(
  parameter int unsigned Depth = 4,
  parameter int unsigned CntW = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [fdss_pkg::ValueW-1:0]  value_i,
  input  logic [CntW-1:0]              level_i,
  output logic                         push_o,
  output fdss_pkg::entry_t             entry_o
);
  import fdss_pkg::*;

  logic                  accept;
  logic [ValueW-1:0]     clamped;
  logic [26:0]           prod;
  logic [CntW:0]         in_flight;
  logic                  s1_valid_q, s1_valid_d;
  kind_e                 s1_kind_q, s1_kind_d;
  logic [ValueW-1:0]     s1_value_q, s1_value_d;
  logic [HundredsW-1:0]  s1_hi_q, s1_hi_d;
  logic [ValueW-1:0]     lo_full;
  logic [2*DigitW-1:0]   hi_digits, lo_digits;

  // hold off when the stage register and the queue could overfill
  assign in_flight  = {1'b0, level_i} + (CntW+1)'(s1_valid_q);
  assign in_stall_o = (in_flight >= (CntW+1)'(Depth));
  assign accept     = in_valid_i && !in_stall_o;

  // clamp and divide by one hundred through the reciprocal
  assign clamped = (value_i > MaxShown) ? MaxShown : value_i;
  assign prod    = 27'(clamped) * 27'(RecipHundred);

  always_comb begin
    s1_valid_d = accept;
    s1_kind_d  = (cmd_i == CmdTick) ? KindTick : KindLoad;
    s1_value_d = clamped;
    s1_hi_d    = prod[RecipHundredShift +: HundredsW];
  end

  // stage register, control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // stage register, payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q  <= s1_kind_d;
      s1_value_q <= s1_value_d;
      s1_hi_q    <= s1_hi_d;
    end
  end

  // remainder below one hundred, then both halves into two digits each
  assign lo_full   = s1_value_q - 14'(s1_hi_q) * 14'(Hundred);
  assign hi_digits = split99(s1_hi_q);
  assign lo_digits = split99(lo_full[HundredsW-1:0]);

  always_comb begin
    entry_o.kind      = s1_kind_q;
    entry_o.value     = s1_value_q;
    entry_o.digits[0] = lo_digits[DigitW-1:0];
    entry_o.digits[1] = lo_digits[2*DigitW-1:DigitW];
    entry_o.digits[2] = hi_digits[DigitW-1:0];
    entry_o.digits[3] = hi_digits[2*DigitW-1:DigitW];
  end

  assign push_o = s1_valid_q;

  // the stage register and the queue never hold more than the queue depth
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight <= (CntW+1)'(Depth))
    else $error("front: requests in flight exceed queue depth");

endmodule

[rtl/fdss_fifo.sv]
// short request queue between the front end and the scan back end
`timescale 1ns / 1ps
module fdss_fifo #(
  parameter int unsigned Depth = 4,
  parameter int unsigned CntW = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fdss_pkg::entry_t  data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output fdss_pkg::entry_t  data_o,
  output logic [CntW-1:0]   count_o
);
  import fdss_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  entry_t             mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

  // queue never written when full nor read when empty
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q < CntW'(Depth))
    else $error("fifo: push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("fifo: pop from an empty queue");

endmodule

[rtl/fdss_back.sv]
// back end: holds the display digits and drives one position per scan tick
`timescale 1ns / 1ps
module fdss_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  fdss_pkg::entry_t                     q_data_i,
  output logic                                 q_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [fdss_pkg::NumDigits-1:0]       digit_enable_o,
  output logic [fdss_pkg::SegW-1:0]            segments_o
);
  import fdss_pkg::*;

  logic [DigitW-1:0]     digit_q [NumDigits];
  logic [DigitW-1:0]     digit_d [NumDigits];
  logic [ValueW-1:0]     shown_q, shown_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic                  out_valid_q, out_valid_d;
  logic [NumDigits-1:0]  out_en_q, out_en_d;
  logic [SegW-1:0]       out_seg_q, out_seg_d;
  logic                  out_free;
  logic                  pop_load, pop_tick;
  logic [SegW-1:0]       seg_raw;

  // a load always drains; a tick needs room in the output register
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_load = q_valid_i && (q_data_i.kind == KindLoad);
  assign pop_tick = q_valid_i && (q_data_i.kind == KindTick) && out_free;
  assign q_pop_o  = pop_load || pop_tick;

  assign seg_raw = seg_lut(digit_q[pos_q]);

  // display state and result register update
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      digit_d[i] = digit_q[i];
    end
    shown_d     = shown_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_en_d    = out_en_q;
    out_seg_d   = out_seg_q;
    if (pop_load) begin
      for (int i = 0; i < NumDigits; i++) begin
        digit_d[i] = q_data_i.digits[i];
      end
      shown_d = q_data_i.value;
    end
    if (pop_tick) begin
      pos_d       = pos_q + 1'b1;
      out_valid_d = 1'b1;
      out_en_d    = pos_lit(pos_q, shown_q) ? (NumDigits'(1) << pos_q) : '0;
      out_seg_d   = (pos_q == PosTens) ? (seg_raw & DpLitMask) : seg_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDigits; i++) begin
        digit_q[i] <= '0;
      end
      shown_q     <= '0;
      pos_q       <= PosOnes;
      out_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < NumDigits; i++) begin
        digit_q[i] <= digit_d[i];
      end
      shown_q     <= shown_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_en_q  <= out_en_d;
    out_seg_q <= out_seg_d;
  end

  assign out_valid_o    = out_valid_q;
  assign digit_enable_o = out_en_q;
  assign segments_o     = out_seg_q;

  // scan position moves by one exactly on a tick
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_tick |=> pos_q == $past(pos_q) + 1'b1)
    else $error("back: scan position did not advance on a tick");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_tick |=> $stable(pos_q))
    else $error("back: scan position moved without a tick");

endmodule

[rtl/four_digit_seven_segment_scanner_top.sv]
// Four-digit multiplexed seven-segment scanner.
//
// Input channel (in_valid_i / in_stall_o): each request carries cmd_i and
// value_i. cmd_i low loads value_i (clamped to 9999) as the new display
// value and gives no result. cmd_i high is a scan tick: it gives one result
// for the next digit position (ones, tens, hundreds, thousands, wrapping).
// Output channel (out_valid_o / out_stall_i): digit_enable_o is one-hot,
// or zero for a blanked leading zero; segments_o is active low with the
// decimal point in bit 7, lit on the tens position.
// A tick's result passes through the front stage register, the queue and
// the output register before it shows on out_valid_o. Throughput is one
// request per cycle while neither in_stall_o nor out_stall_i is raised.
// Reset clears the display value to zero and the scan position to ones.
// While the receiver stalls, the result is held and requests gather in a
// QueueDepth-entry queue; in_stall_o rises once the queue and the front
// stage register together hold QueueDepth requests. Loads drain past a
// stalled output.
`timescale 1ns / 1ps
module four_digit_seven_segment_scanner_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic [fdss_pkg::ValueW-1:0]         value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fdss_pkg::NumDigits-1:0]      digit_enable_o,
  output logic [fdss_pkg::SegW-1:0]           segments_o
);
  import fdss_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic              push;
  entry_t            push_entry;
  logic              q_valid;
  entry_t            q_entry;
  logic              q_pop;
  logic [CntW-1:0]   q_count;

  // request intake and digit split
  fdss_front #(
    .Depth (QueueDepth),
    .CntW  (CntW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .level_i    (q_count),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // decoupling queue
  fdss_fifo #(
    .Depth (QueueDepth),
    .CntW  (CntW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_entry),
    .count_o (q_count)
  );

  // display state and scan output
  fdss_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_entry),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digit_enable_o (digit_enable_o),
    .segments_o     (segments_o)
  );

endmodule
